[rtl/core/isl_pkg.sv]
// isl_pkg: shared types and constants for the iSLIP crossbar scheduler.
// No dependencies; imported by isl_rr_arbiter and the top level.
`default_nettype none

package isl_pkg;

    localparam int MAX_PORTS  = 8;
    localparam int PORT_W     = 3;
    localparam int MATRIX_W   = MAX_PORTS * MAX_PORTS;
    localparam int ITER_W     = 4;

    localparam logic [ITER_W-1:0] ITER_RESET = 4'd2;

    // Result of one round-robin pick.
    typedef struct packed {
        logic              found;
        logic [PORT_W-1:0] idx;
    } arb_pick_t;

endpackage

`default_nettype wire

[rtl/core/isl_rr_arbiter.sv]
// isl_rr_arbiter: round-robin pick of the first set bit at or after a pointer,
// wrapping at PORTS. Depends on isl_pkg.
`default_nettype none

module isl_rr_arbiter #(
    parameter int PORTS = 8
) (
    input  wire logic [isl_pkg::MAX_PORTS-1:0] req,
    input  wire logic [isl_pkg::PORT_W-1:0]    ptr,
    output isl_pkg::arb_pick_t                 pick
);
    import isl_pkg::*;

    // Walk from the far end back so the nearest candidate wins.
    always_comb
    begin
        logic [PORT_W:0] cand;
        pick = '0;
        for (int k = PORTS - 1; k >= 0; k--)
        begin
            cand = {1'b0, ptr} + (PORT_W + 1)'(k);
            if (cand >= (PORT_W + 1)'(PORTS))
            begin
                cand = cand - (PORT_W + 1)'(PORTS);
            end
            if (req[cand[PORT_W-1:0]])
            begin
                pick.found = 1'b1;
                pick.idx   = cand[PORT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/islip_crossbar_scheduler_unit.sv]
// islip_crossbar_scheduler_unit: iSLIP matching over a PORTS x PORTS crossbar.
// Depends on isl_pkg and isl_rr_arbiter.
`default_nettype none

//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  in       | in_valid / in_ready        | request_matrix[63:0]
//  out      | out_valid / out_ready      | match_matrix[63:0], matched_inputs[7:0]
//  cfg      | cfg_valid / cfg_ready (=1) | cfg_data[3:0] -> iteration_count
//
// One round-robin arbiter serves every grant and accept decision: each iteration
// steps through the grant phase (one output per cycle), then the accept phase
// (one input per cycle). The result is registered in the finish state and
// in_ready rises with it, so a new request is taken only after the last result
// is registered. A stalled out channel holds the finish state until the output
// register frees. Reset zeroes pointers, iteration_count 2.

module islip_crossbar_scheduler_unit #(
    parameter int PORTS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [isl_pkg::MATRIX_W-1:0]  request_matrix,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [isl_pkg::MATRIX_W-1:0]       match_matrix,
    output logic [isl_pkg::MAX_PORTS-1:0]      matched_inputs,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [isl_pkg::ITER_W-1:0]    cfg_data
);
    import isl_pkg::*;

    localparam int PIDX_W = $clog2(PORTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GRANT  = 2'd1;
    localparam logic [1:0] ST_ACCEPT = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [ITER_W-1:0]       iter_cfg_reg, iter_cfg_next;
    logic [ITER_W-1:0]       iter_idx_reg, iter_idx_next;
    logic [PIDX_W-1:0]       port_idx_reg, port_idx_next;
    logic [MATRIX_W-1:0]     req_reg, req_next;
    logic [MATRIX_W-1:0]     grant_reg, grant_next;
    logic [MATRIX_W-1:0]     match_reg, match_next;
    logic [MAX_PORTS-1:0]    in_matched_reg, in_matched_next;
    logic [MAX_PORTS-1:0]    out_matched_reg, out_matched_next;
    logic [PORT_W-1:0]       gp_reg [PORTS];
    logic [PORT_W-1:0]       gp_next [PORTS];
    logic [PORT_W-1:0]       ap_reg [PORTS];
    logic [PORT_W-1:0]       ap_next [PORTS];
    logic                    out_valid_reg, out_valid_next;
    logic [MATRIX_W-1:0]     out_match_reg, out_match_next;
    logic [MAX_PORTS-1:0]    out_inputs_reg, out_inputs_next;

    logic [MAX_PORTS-1:0]    arb_req;
    logic [PORT_W-1:0]       arb_ptr;
    arb_pick_t               arb_pick;
    logic [PORT_W-1:0]       port3;
    logic                    last_port;
    logic                    last_iter;

    function automatic logic [PORT_W-1:0] next_port(input logic [PORT_W-1:0] p);
        logic [PORT_W:0] s;
        s = {1'b0, p} + (PORT_W + 1)'(1);
        if (s == (PORT_W + 1)'(PORTS))
        begin
            s = '0;
        end
        return s[PORT_W-1:0];
    endfunction

    isl_rr_arbiter #(
        .PORTS (PORTS)
    ) u_arb (
        .req  (arb_req),
        .ptr  (arb_ptr),
        .pick (arb_pick)
    );

    assign port3     = PORT_W'(port_idx_reg);
    assign last_port = (port_idx_reg == PIDX_W'(PORTS - 1));
    assign last_iter = ((iter_idx_reg + ITER_W'(1)) == iter_cfg_reg);

    assign in_ready       = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign match_matrix   = out_match_reg;
    assign matched_inputs = out_inputs_reg;

    // Arbiter operands: requesting inputs per output in grant phase,
    // granting outputs per input in accept phase.
    always_comb
    begin
        logic [MAX_PORTS-1:0] row;
        row     = '0;
        arb_req = '0;
        arb_ptr = '0;
        if (state_reg == ST_GRANT)
        begin
            arb_ptr = gp_reg[port_idx_reg];
            for (int c = 0; c < PORTS; c++)
            begin
                row = req_reg[c*MAX_PORTS +: MAX_PORTS];
                arb_req[c] = row[port3] && !in_matched_reg[c];
            end
        end
        else
        begin
            arb_ptr = ap_reg[port_idx_reg];
            arb_req = grant_reg[{port3, 3'b000} +: MAX_PORTS];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        iter_cfg_next    = iter_cfg_reg;
        iter_idx_next    = iter_idx_reg;
        port_idx_next    = port_idx_reg;
        req_next         = req_reg;
        grant_next       = grant_reg;
        match_next       = match_reg;
        in_matched_next  = in_matched_reg;
        out_matched_next = out_matched_reg;
        gp_next          = gp_reg;
        ap_next          = ap_reg;
        out_valid_next   = out_valid_reg;
        out_match_next   = out_match_reg;
        out_inputs_next  = out_inputs_reg;

        if (cfg_valid)
        begin
            iter_cfg_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next         = request_matrix;
                    grant_next       = '0;
                    match_next       = '0;
                    in_matched_next  = '0;
                    out_matched_next = '0;
                    iter_idx_next    = '0;
                    port_idx_next    = '0;
                    state_next       = (iter_cfg_reg == '0) ? ST_FINISH : ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (!out_matched_reg[port3] && arb_pick.found)
                begin
                    grant_next[{arb_pick.idx, port3}] = 1'b1;
                end
                port_idx_next = last_port ? '0 : port_idx_reg + PIDX_W'(1);
                if (last_port)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            ST_ACCEPT:
            begin
                if (!in_matched_reg[port3] && arb_pick.found)
                begin
                    if (iter_idx_reg == '0)
                    begin
                        ap_next[port_idx_reg] = next_port(arb_pick.idx);
                        gp_next[arb_pick.idx[PIDX_W-1:0]] = next_port(port3);
                    end
                    in_matched_next[port3]          = 1'b1;
                    out_matched_next[arb_pick.idx]  = 1'b1;
                    match_next[{port3, arb_pick.idx}] = 1'b1;
                end
                port_idx_next = last_port ? '0 : port_idx_reg + PIDX_W'(1);
                if (last_port)
                begin
                    grant_next    = '0;
                    iter_idx_next = iter_idx_reg + ITER_W'(1);
                    state_next    = last_iter ? ST_FINISH : ST_GRANT;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_match_next  = match_reg;
                    out_inputs_next = in_matched_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_cfg_reg  <= ITER_RESET;
            iter_idx_reg  <= '0;
            port_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < PORTS; p++)
            begin
                gp_reg[p] <= '0;
                ap_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            iter_cfg_reg  <= iter_cfg_next;
            iter_idx_reg  <= iter_idx_next;
            port_idx_reg  <= port_idx_next;
            out_valid_reg <= out_valid_next;
            for (int p = 0; p < PORTS; p++)
            begin
                gp_reg[p] <= gp_next[p];
                ap_reg[p] <= ap_next[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        grant_reg       <= grant_next;
        match_reg       <= match_next;
        in_matched_reg  <= in_matched_next;
        out_matched_reg <= out_matched_next;
        out_match_reg   <= out_match_next;
        out_inputs_reg  <= out_inputs_next;
    end

endmodule

`default_nettype wire

[verif/islip_crossbar_scheduler_unit_test.sv]
// Testbench for islip_crossbar_scheduler_unit: table-driven and random request
// matrices, checked against a built-in iSLIP matcher model. Needs isl_pkg and the RTL.
`timescale 1ns / 100ps

module islip_crossbar_scheduler_unit_test;

    localparam int N_PORTS      = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int RANDOM_PHASES = 9;
    localparam int PLAN_ROWS    = 23;
    localparam int SETTLE_CYCLES = 2 * N_PORTS * 16 + 8;

    localparam bit KNOWN   = 1'b1;   // expected result typed into the table
    localparam bit PREDICT = 1'b0;   // expected result comes from the model

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DIAGONAL  = 64'h8040_2010_0804_0201;
    localparam logic [63:0] ANTI_DIAG = 64'h0102_0408_1020_4080;

    typedef struct packed {
        logic [isl_pkg::ITER_W-1:0]    iters;
        logic [isl_pkg::MATRIX_W-1:0]  req;
        logic                          known;
        logic [isl_pkg::MATRIX_W-1:0]  match;
        logic [isl_pkg::MAX_PORTS-1:0] inputs;
    } plan_row_t;

    typedef struct packed {
        logic [isl_pkg::MATRIX_W-1:0]  match;
        logic [isl_pkg::MAX_PORTS-1:0] inputs;
    } match_result_t;

    // iterations, request, known, match, matched inputs
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        {4'd2,  64'h0,                  KNOWN,   64'h0,                  8'h00},
        {4'd2,  64'h8000_0000_0000_0000, KNOWN,  64'h8000_0000_0000_0000, 8'h80},
        {4'd2,  64'h1,                  KNOWN,   64'h1,                  8'h01},
        {4'd2,  ALL_ONES,               PREDICT, 64'h0,                  8'h00},
        {4'd2,  ALL_ONES,               PREDICT, 64'h0,                  8'h00},
        {4'd2,  64'h0101_0101_0101_0101, PREDICT, 64'h0,                 8'h00},
        {4'd2,  64'h0000_0000_0000_00FF, PREDICT, 64'h0,                 8'h00},
        {4'd2,  DIAGONAL,               KNOWN,   DIAGONAL,               8'hFF},
        {4'd2,  ANTI_DIAG,              KNOWN,   ANTI_DIAG,              8'hFF},
        {4'd2,  64'hAAAA_AAAA_AAAA_AAAA, PREDICT, 64'h0,                 8'h00},
        {4'd2,  64'h5555_5555_5555_5555, PREDICT, 64'h0,                 8'h00},
        {4'd0,  ALL_ONES,               KNOWN,   64'h0,                  8'h00},
        {4'd0,  DIAGONAL,               KNOWN,   64'h0,                  8'h00},
        {4'd15, ALL_ONES,               PREDICT, 64'h0,                  8'h00},
        {4'd15, 64'h8080_8080_8080_8080, PREDICT, 64'h0,                 8'h00},
        {4'd15, 64'hFFFF_FFFF_0000_0000, PREDICT, 64'h0,                 8'h00},
        {4'd1,  DIAGONAL,               KNOWN,   DIAGONAL,               8'hFF},
        {4'd1,  ALL_ONES,               PREDICT, 64'h0,                  8'h00},
        {4'd1,  64'h0000_0000_FFFF_FFFF, PREDICT, 64'h0,                 8'h00},
        {4'd8,  ALL_ONES,               PREDICT, 64'h0,                  8'h00},
        {4'd8,  64'hFF00_0000_0000_0000, PREDICT, 64'h0,                 8'h00},
        {4'd8,  64'h0,                  KNOWN,   64'h0,                  8'h00},
        {4'd4,  64'h3C5A_96E1_0F87_D24B, PREDICT, 64'h0,                 8'h00}
    };

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          in_valid       = 1'b0;
    logic                          in_ready;
    logic [isl_pkg::MATRIX_W-1:0]  request_matrix = '0;
    logic                          out_valid;
    logic                          out_ready      = 1'b0;
    logic [isl_pkg::MATRIX_W-1:0]  match_matrix;
    logic [isl_pkg::MAX_PORTS-1:0] matched_inputs;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [isl_pkg::ITER_W-1:0]    cfg_data       = '0;

    // model state
    logic [isl_pkg::PORT_W-1:0]    grant_ptr  [N_PORTS];
    logic [isl_pkg::PORT_W-1:0]    accept_ptr [N_PORTS];
    logic [isl_pkg::ITER_W-1:0]    iterations = isl_pkg::ITER_RESET;

    match_result_t expected_matches [$];
    int            mismatch_count = 0;
    int            burst_left     = 0;

    // receiver stall pattern
    int            stall_left = 0;
    int            stall_mode = 0;
    logic [15:0]   stall_pat  = 16'hFFFF;
    logic [3:0]    stall_pos  = '0;

    islip_crossbar_scheduler_unit #(
        .PORTS(N_PORTS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .request_matrix (request_matrix),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match_matrix   (match_matrix),
        .matched_inputs (matched_inputs),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int p = 0; p < N_PORTS; p++)
        begin
            grant_ptr[p]  = '0;
            accept_ptr[p] = '0;
        end
    end

    // One time slot of iSLIP; pointers only move on first-iteration accepts.
    function automatic void islip_match(input logic [63:0] req,
                                        output logic [63:0] match,
                                        output logic [7:0] in_done);
        logic [7:0] out_done;
        logic [7:0] grants [N_PORTS];
        bit         picked;
        int         cand;
        match    = '0;
        in_done  = '0;
        out_done = '0;
        for (int it = 0; it < int'(iterations); it++)
        begin
            for (int i = 0; i < N_PORTS; i++)
                grants[i] = '0;
            for (int o = 0; o < N_PORTS; o++)
            begin
                picked = 1'b0;
                for (int k = 0; k < N_PORTS; k++)
                begin
                    cand = (int'(grant_ptr[o]) + k) % N_PORTS;
                    if (!out_done[o] && !picked && !in_done[cand] && req[cand * 8 + o])
                    begin
                        grants[cand][o] = 1'b1;
                        picked = 1'b1;
                    end
                end
            end
            for (int i = 0; i < N_PORTS; i++)
            begin
                picked = in_done[i];
                for (int k = 0; k < N_PORTS; k++)
                begin
                    cand = (int'(accept_ptr[i]) + k) % N_PORTS;
                    if (!picked && grants[i][cand])
                    begin
                        if (it == 0)
                        begin
                            accept_ptr[i]   = 3'((cand + 1) % N_PORTS);
                            grant_ptr[cand] = 3'((i + 1) % N_PORTS);
                        end
                        in_done[i]          = 1'b1;
                        out_done[cand]      = 1'b1;
                        match[i * 8 + cand] = 1'b1;
                        picked = 1'b1;
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sender works in bursts; valid stays up across back-to-back requests.
    task automatic send_request(input logic [63:0] req, input bit known,
                                input logic [63:0] want_match, input logic [7:0] want_inputs);
        logic [63:0]   m;
        logic [7:0]    mi;
        match_result_t res;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid       <= 1'b1;
        request_matrix <= req;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        islip_match(req, m, mi);
        if (known)
            res = '{match: want_match, inputs: want_inputs};
        else
            res = '{match: m, inputs: mi};
        expected_matches = {expected_matches, res};
    endtask

    // Only written with no request in flight.
    task automatic write_iterations(input logic [3:0] value);
        in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        iterations = value;
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 80);
            stall_pat  <= 16'($urandom);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        stall_pos <= stall_pos + 1'b1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= stall_pat[stall_pos];
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_matches.size() == 0)
            begin
                report_mismatch("unexpected result", match_matrix, 64'h0);
            end
            else
            begin
                want = expected_matches.pop_front();
                if (match_matrix !== want.match)
                    report_mismatch("match_matrix", match_matrix, want.match);
                if (matched_inputs !== want.inputs)
                    report_mismatch("matched_inputs", {56'h0, matched_inputs},
                                    {56'h0, want.inputs});
            end
        end
    end

    initial
    begin
        logic [63:0] req;
        logic [63:0] a;
        logic [63:0] b;
        logic [3:0]  phase_iters;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < PLAN_ROWS; n++)
        begin
            if (PLAN[n].iters != iterations)
                write_iterations(PLAN[n].iters);
            send_request(PLAN[n].req, PLAN[n].known, PLAN[n].match, PLAN[n].inputs);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: phase_iters = 4'd1;
                1: phase_iters = 4'd15;
                2: phase_iters = 4'd3;
                3: phase_iters = 4'd0;
                4: phase_iters = 4'd8;
                5: phase_iters = 4'd2;
                8: phase_iters = 4'd5;
                default: phase_iters = 4'($urandom_range(0, 15));
            endcase
            write_iterations(phase_iters);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                a = {$urandom, $urandom};
                b = {$urandom, $urandom};
                // mix of densities so that contention and idle ports both show up
                case ($urandom_range(0, 9))
                    0: req = '0;
                    1: req = ALL_ONES;
                    2, 3: req = a;
                    4, 5: req = a & b & {$urandom, $urandom};
                    6: req = a | b;
                    7: req = {56'h0, a[7:0]} << (8 * $urandom_range(0, 7));
                    8: req = b & (64'h0101_0101_0101_0101 << $urandom_range(0, 7));
                    default: req = 64'h1 << $urandom_range(0, 63);
                endcase
                send_request(req, PREDICT, 64'h0, 8'h00);
            end
        end
        in_valid <= 1'b0;

        while (expected_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
